// ----- hdl/kdfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the mode lookup for the metadata block parser.
package kdfp_pkg;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_PREAMBLE = 4'b0001,
    PH_HEADER   = 4'b0010,
    PH_VALUE    = 4'b0100,
    PH_DONE     = 4'b1000
  } kdfp_phase_e;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FORMAT  = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FLAG_BITS = 1'b0;
  localparam logic CFG_KEY_SIZE  = 1'b1;

  // Known TLV types.
  localparam logic [15:0] TYPE_TIME_COST = 16'h0001;
  localparam logic [15:0] TYPE_MEMORY    = 16'h0002;
  localparam logic [15:0] TYPE_LANES     = 16'h0003;
  localparam logic [15:0] TYPE_KEY_SIZE  = 16'h0004;
  localparam logic [15:0] TYPE_REVISION  = 16'h0005;
  localparam logic [15:0] TYPE_MODE      = 16'h0010;

  // Value lengths of the known types.
  localparam logic [31:0] LEN_WORD = 32'd4;
  localparam logic [31:0] LEN_MODE = 32'd2;

  // Preamble version word: major 1, minor 0.
  localparam logic [31:0] VERSION_1_0 = 32'h0000_0001;

  // Defaults of the parsed values.
  localparam logic [31:0] DEF_TIME_COST = 32'd3;
  localparam logic [31:0] DEF_MEMORY    = 32'd65536;
  localparam logic [31:0] DEF_LANES     = 32'd1;
  localparam logic [31:0] DEF_REVISION  = 32'h0000_0013;
  localparam logic [3:0]  DEF_MODE_BITS = 4'h1;

  // Configuration reset values.
  localparam logic [3:0]  RST_FLAG_BITS = 4'h1;
  localparam logic [31:0] RST_KEY_SIZE  = 32'd32;

  // Composite-mode codes at or above this are invalid.
  localparam logic [15:0] MODE_CODE_LIMIT = 16'd15;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_block;
  } kdfp_item_t;

  // Configuration seen by the parser.
  typedef struct packed {
    logic [3:0]  flag_bits;
    logic [31:0] key_size;
  } kdfp_cfg_t;

  // One result; status sits in the lowest bits.
  typedef struct packed {
    logic        mode_seen;
    logic        want_token;
    logic        want_keyfile;
    logic        want_biometric;
    logic        want_password;
    logic [15:0] mode_code;
    logic [31:0] kdf_revision;
    logic [31:0] lanes;
    logic [31:0] memory_kib;
    logic [31:0] time_cost;
    logic [1:0]  status;
  } kdfp_result_t;

  // Factor set (bit0 password .. bit3 token) of a valid composite-mode code.
  function automatic logic [3:0] mode_factors(input logic [3:0] code);
    logic [3:0] f;
    case (code)
      4'd0:    f = 4'h1;
      4'd1:    f = 4'h2;
      4'd2:    f = 4'h3;
      4'd3:    f = 4'h5;
      4'd4:    f = 4'h9;
      4'd5:    f = 4'h7;
      4'd6:    f = 4'hB;
      4'd7:    f = 4'hD;
      4'd8:    f = 4'hF;
      4'd9:    f = 4'h4;
      4'd10:   f = 4'h8;
      4'd11:   f = 4'h6;
      4'd12:   f = 4'hA;
      4'd13:   f = 4'hC;
      4'd14:   f = 4'hE;
      default: f = 4'h0;
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/kdfp_in_reg.sv -----
`timescale 1ns / 1ps
// Input register stage that holds one accepted word until the parser takes it.
module kdfp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kdfp_pkg::kdfp_item_t in_item_i,
  input  logic               pop_i,
  output logic               item_valid_o,
  output kdfp_pkg::kdfp_item_t item_o
);

  logic                 valid_q;
  logic                 run_q;
  kdfp_pkg::kdfp_item_t item_q;

  // The register can take a word when it is empty or drains in this cycle.
  assign in_ready_o   = run_q && (!valid_q || pop_i);
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      run_q <= 1'b1;
      if (in_valid_i && in_ready_o) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ----- hdl/kdfp_core.sv -----
`timescale 1ns / 1ps
// Parser state and the single-pass next-state and result logic.
module kdfp_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  kdfp_pkg::kdfp_item_t   item_i,
  input  logic                   slot_free_i,
  input  kdfp_pkg::kdfp_cfg_t    cfg_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  output kdfp_pkg::kdfp_result_t res_o
);

  kdfp_pkg::kdfp_phase_e phase_q, phase_d;
  logic [2:0]  bis_q, bis_d;
  logic [31:0] tlvs_q, tlvs_d;
  logic [31:0] vleft_q, vleft_d;
  logic [15:0] ctype_q, ctype_d;
  logic [31:0] hshift_q, hshift_d;
  logic [31:0] vshift_q, vshift_d;
  logic [1:0]  err_q, err_d;
  logic [31:0] cost_q, cost_d;
  logic [31:0] mem_q, mem_d;
  logic [31:0] lanes_q, lanes_d;
  logic [31:0] rev_q, rev_d;
  logic [15:0] mcode_q, mcode_d;
  logic [3:0]  mbits_q, mbits_d;
  logic        mseen_q, mseen_d;

  logic        ends;
  logic        fire;
  logic        len_ok;
  logic        val_ok;
  logic [4:0]  lane_sh;
  logic [3:0]  bits;
  logic [1:0]  status;

  assign ends        = item_i.empty_block || item_i.last_byte;
  assign fire        = item_valid_i && (!ends || slot_free_i);
  assign pop_o       = fire;
  assign res_valid_o = fire && ends;
  assign lane_sh     = {bis_q[1:0], 3'b000};

  always_comb begin
    phase_d  = phase_q;
    bis_d    = bis_q;
    tlvs_d   = tlvs_q;
    vleft_d  = vleft_q;
    ctype_d  = ctype_q;
    hshift_d = hshift_q;
    vshift_d = vshift_q;
    err_d    = err_q;
    cost_d   = cost_q;
    mem_d    = mem_q;
    lanes_d  = lanes_q;
    rev_d    = rev_q;
    mcode_d  = mcode_q;
    mbits_d  = mbits_q;
    mseen_d  = mseen_q;
    len_ok   = 1'b1;
    val_ok   = 1'b1;

    if (!item_i.empty_block) begin
      unique case (phase_q)
        kdfp_pkg::PH_PREAMBLE: begin
          if (!bis_q[2]) begin
            hshift_d = hshift_q | (32'(item_i.data_byte) << lane_sh);
          end else begin
            vshift_d = vshift_q | (32'(item_i.data_byte) << lane_sh);
          end
          bis_d = bis_q + 3'd1;
          if (bis_q == 3'd7) begin
            if (hshift_d != kdfp_pkg::VERSION_1_0) begin
              err_d   = kdfp_pkg::ST_VERSION;
              phase_d = kdfp_pkg::PH_DONE;
            end else begin
              tlvs_d  = vshift_d;
              phase_d = (vshift_d == 32'd0) ? kdfp_pkg::PH_DONE : kdfp_pkg::PH_HEADER;
            end
          end
        end

        kdfp_pkg::PH_HEADER: begin
          if (bis_q == 3'd0) begin
            ctype_d  = {8'h00, item_i.data_byte};
            hshift_d = 32'd0;
          end else if (bis_q == 3'd1) begin
            ctype_d = {item_i.data_byte, ctype_q[7:0]};
          end else if (bis_q[2]) begin
            hshift_d = hshift_q | (32'(item_i.data_byte) << lane_sh);
          end
          bis_d = bis_q + 3'd1;
          if (bis_q == 3'd7) begin
            case (ctype_q) inside
              kdfp_pkg::TYPE_TIME_COST, kdfp_pkg::TYPE_MEMORY, kdfp_pkg::TYPE_LANES,
              kdfp_pkg::TYPE_KEY_SIZE, kdfp_pkg::TYPE_REVISION:
                len_ok = (hshift_d == kdfp_pkg::LEN_WORD);
              kdfp_pkg::TYPE_MODE:
                len_ok = (hshift_d == kdfp_pkg::LEN_MODE);
              default:
                len_ok = 1'b1;
            endcase
            if (!len_ok) begin
              err_d   = kdfp_pkg::ST_FORMAT;
              phase_d = kdfp_pkg::PH_DONE;
            end else begin
              vleft_d  = hshift_d;
              vshift_d = 32'd0;
              if (hshift_d == 32'd0) begin
                // An unknown type with an empty value ends its TLV right here.
                tlvs_d  = tlvs_q - 32'd1;
                phase_d = (tlvs_q == 32'd1) ? kdfp_pkg::PH_DONE : kdfp_pkg::PH_HEADER;
                bis_d   = 3'd0;
              end else begin
                phase_d = kdfp_pkg::PH_VALUE;
              end
            end
          end
        end

        kdfp_pkg::PH_VALUE: begin
          vshift_d = {item_i.data_byte, vshift_q[31:8]};
          vleft_d  = vleft_q - 32'd1;
          if (vleft_q == 32'd1) begin
            case (ctype_q)
              kdfp_pkg::TYPE_TIME_COST: cost_d  = vshift_d;
              kdfp_pkg::TYPE_MEMORY:    mem_d   = vshift_d;
              kdfp_pkg::TYPE_LANES:     lanes_d = vshift_d;
              kdfp_pkg::TYPE_REVISION:  rev_d   = vshift_d;
              kdfp_pkg::TYPE_KEY_SIZE:  val_ok  = (vshift_d == cfg_i.key_size);
              kdfp_pkg::TYPE_MODE: begin
                // The two value bytes land in the upper half of the shifter.
                mcode_d = vshift_d[31:16];
                mseen_d = 1'b1;
                if (vshift_d[31:16] < kdfp_pkg::MODE_CODE_LIMIT) begin
                  mbits_d = kdfp_pkg::mode_factors(vshift_d[19:16]);
                end else begin
                  mbits_d = 4'h0;
                  val_ok  = 1'b0;
                end
              end
              default: val_ok = 1'b1;
            endcase
            if (!val_ok) begin
              err_d   = kdfp_pkg::ST_FORMAT;
              phase_d = kdfp_pkg::PH_DONE;
            end else begin
              tlvs_d  = tlvs_q - 32'd1;
              phase_d = (tlvs_q == 32'd1) ? kdfp_pkg::PH_DONE : kdfp_pkg::PH_HEADER;
              bis_d   = 3'd0;
            end
          end
        end

        kdfp_pkg::PH_DONE: begin
          phase_d = kdfp_pkg::PH_DONE;
        end

        default: begin
          phase_d = kdfp_pkg::PH_DONE;
        end
      endcase
    end

    // Status and factor bits of the block as it stands after this word.
    if (err_d != kdfp_pkg::ST_OK) begin
      status = err_d;
    end else if (phase_d != kdfp_pkg::PH_DONE) begin
      status = kdfp_pkg::ST_FORMAT;
    end else if (mseen_d && (mbits_d != cfg_i.flag_bits)) begin
      status = kdfp_pkg::ST_FORMAT;
    end else begin
      status = kdfp_pkg::ST_OK;
    end
    bits = mseen_d ? mbits_d : cfg_i.flag_bits;

    res_o.status         = status;
    res_o.time_cost      = cost_d;
    res_o.memory_kib     = mem_d;
    res_o.lanes          = lanes_d;
    res_o.kdf_revision   = rev_d;
    res_o.mode_code      = mcode_d;
    res_o.want_password  = bits[0];
    res_o.want_biometric = bits[1];
    res_o.want_keyfile   = bits[2];
    res_o.want_token     = bits[3];
    res_o.mode_seen      = mseen_d;

    // The end of a block returns the parser to its starting state.
    if (ends) begin
      phase_d  = kdfp_pkg::PH_PREAMBLE;
      bis_d    = 3'd0;
      tlvs_d   = 32'd0;
      vleft_d  = 32'd0;
      ctype_d  = 16'd0;
      hshift_d = 32'd0;
      vshift_d = 32'd0;
      err_d    = kdfp_pkg::ST_OK;
      cost_d   = kdfp_pkg::DEF_TIME_COST;
      mem_d    = kdfp_pkg::DEF_MEMORY;
      lanes_d  = kdfp_pkg::DEF_LANES;
      rev_d    = kdfp_pkg::DEF_REVISION;
      mcode_d  = 16'd0;
      mbits_d  = kdfp_pkg::DEF_MODE_BITS;
      mseen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= kdfp_pkg::PH_PREAMBLE;
      bis_q    <= 3'd0;
      tlvs_q   <= 32'd0;
      vleft_q  <= 32'd0;
      ctype_q  <= 16'd0;
      hshift_q <= 32'd0;
      vshift_q <= 32'd0;
      err_q    <= kdfp_pkg::ST_OK;
      cost_q   <= kdfp_pkg::DEF_TIME_COST;
      mem_q    <= kdfp_pkg::DEF_MEMORY;
      lanes_q  <= kdfp_pkg::DEF_LANES;
      rev_q    <= kdfp_pkg::DEF_REVISION;
      mcode_q  <= 16'd0;
      mbits_q  <= kdfp_pkg::DEF_MODE_BITS;
      mseen_q  <= 1'b0;
    end else if (fire) begin
      phase_q  <= phase_d;
      bis_q    <= bis_d;
      tlvs_q   <= tlvs_d;
      vleft_q  <= vleft_d;
      ctype_q  <= ctype_d;
      hshift_q <= hshift_d;
      vshift_q <= vshift_d;
      err_q    <= err_d;
      cost_q   <= cost_d;
      mem_q    <= mem_d;
      lanes_q  <= lanes_d;
      rev_q    <= rev_d;
      mcode_q  <= mcode_d;
      mbits_q  <= mbits_d;
      mseen_q  <= mseen_d;
    end
  end

endmodule

// ----- hdl/kdfp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register that holds one finished result until the receiver takes it.
module kdfp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  kdfp_pkg::kdfp_result_t res_i,
  input  logic                   ready_i,
  output logic                   valid_o,
  output logic                   slot_free_o,
  output kdfp_pkg::kdfp_result_t res_o
);

  logic                   valid_q;
  kdfp_pkg::kdfp_result_t res_q;

  assign valid_o     = valid_q;
  assign res_o       = res_q;
  assign slot_free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hdl/kdf_tlv_block_parser.sv -----
`timescale 1ns / 1ps
// Top level of the key-derivation metadata block parser.
//
// Usage: the slave side takes one byte of a metadata block per word. tdata
// carries the byte, tlast marks the final byte of the block, and tuser marks
// a word that carries no byte and ends the block where it stands (this is how
// a zero-length block is closed). Each block end produces exactly one result
// word on the master side with the status and the parsed parameter values.
// Bytes inside a block produce nothing on the master side.
// A word is accepted into the input register and parsed from there by the
// core, which updates the parser state; the result of a block-ending word is
// loaded into the result register once that register is free. Throughput is
// one word per cycle unless a block-ending word waits for the result register.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_wdata_i
// while no block is in flight: index 0 holds the four factor flag bits,
// index 1 the required key size.
// Reset clears the parser to the start of a block, empties both registers,
// and restores flag bits 1 and key size 32. s_axis_tready is low during reset.
// When the receiver stalls, the finished result holds in the result register;
// bytes that end no block keep flowing, and a block-ending word waits in the
// input register until the result register frees up.
module kdf_tlv_block_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Slave side.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  input  logic         s_axis_tuser,   // [0] empty_block
  // Master side.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [33:2] time_cost, [65:34] memory_kib, [97:66] lanes,
  // [129:98] kdf_revision, [145:130] mode_code, [146] want_password,
  // [147] want_biometric, [148] want_keyfile, [149] want_token,
  // [150] mode_seen, [151] zero
  output logic [151:0] m_axis_tdata,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_wdata_i
);

  logic [3:0]  flag_bits_q;
  logic [31:0] key_size_q;

  kdfp_pkg::kdfp_item_t   in_item;
  kdfp_pkg::kdfp_item_t   item;
  kdfp_pkg::kdfp_cfg_t    cfg;
  kdfp_pkg::kdfp_result_t core_res;
  kdfp_pkg::kdfp_result_t out_res;
  logic                   item_valid;
  logic                   pop;
  logic                   res_valid;
  logic                   slot_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_bits_q <= kdfp_pkg::RST_FLAG_BITS;
      key_size_q  <= kdfp_pkg::RST_KEY_SIZE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kdfp_pkg::CFG_FLAG_BITS: flag_bits_q <= cfg_wdata_i[3:0];
        kdfp_pkg::CFG_KEY_SIZE:  key_size_q  <= cfg_wdata_i;
        default:                 key_size_q  <= key_size_q;
      endcase
    end
  end

  assign cfg.flag_bits = flag_bits_q;
  assign cfg.key_size  = key_size_q;

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.last_byte   = s_axis_tlast;
  assign in_item.empty_block = s_axis_tuser;

  kdfp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  kdfp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .slot_free_i  (slot_free),
    .cfg_i        (cfg),
    .pop_o        (pop),
    .res_valid_o  (res_valid),
    .res_o        (core_res)
  );

  kdfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (core_res),
    .ready_i     (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .slot_free_o (slot_free),
    .res_o       (out_res)
  );

  // The result struct is laid out with status in the lowest bits.
  assign m_axis_tdata = {1'b0, out_res};

endmodule

// ----- hdl/kdfp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the metadata block parser and its bind.
module kdfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata
);

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[1:0] == kdfp_pkg::ST_OK) ||
       (m_axis_tdata[1:0] == kdfp_pkg::ST_FORMAT) ||
       (m_axis_tdata[1:0] == kdfp_pkg::ST_VERSION)) && !m_axis_tdata[151])
    else $error("invalid status code or padding bit set");

  // A version failure stops parsing at the preamble, so all values are defaults.
  a_version_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == kdfp_pkg::ST_VERSION) |->
      (m_axis_tdata[33:2] == kdfp_pkg::DEF_TIME_COST) &&
      (m_axis_tdata[65:34] == kdfp_pkg::DEF_MEMORY) &&
      (m_axis_tdata[97:66] == kdfp_pkg::DEF_LANES) &&
      (m_axis_tdata[129:98] == kdfp_pkg::DEF_REVISION) &&
      (m_axis_tdata[145:130] == 16'd0) && !m_axis_tdata[150])
    else $error("version failure reported with parsed values");

  // A result starts only from an accepted block-ending word that passed through the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser), 2))
    else $error("result without a block-ending word");

endmodule

bind kdf_tlv_block_parser kdfp_checker u_kdfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/kdf_tlv_block_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the metadata block parser: byte stream in, result words out.
//
// The stimulus process builds metadata blocks as byte queues and hands them to a
// clocked driver, one word per byte. Every word that the parser accepts is also
// run through a parser model kept here, which queues the result word that each
// block end must produce. A clocked monitor pops that queue on every result word
// and compares it field by field. The run steps through several settings of the
// two configuration registers. Each setting is written only after the parser has
// drained. One phase holds off the result side for a long stretch while blocks
// keep arriving, and one phase runs without any idle cycles on either side.
module kdf_tlv_block_parser_tb;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_WORDS  = 280;
  localparam int NUM_SETTINGS = 6;
  localparam int WATCHDOG_NS  = 5_000_000;

  // Factor set of each valid composite-mode code, code 0 in the lowest nibble.
  localparam logic [59:0] FACTOR_SETS = {
    4'hE, 4'hC, 4'hA, 4'h6, 4'h8, 4'h4, 4'hF, 4'hD,
    4'hB, 4'h7, 4'h9, 4'h5, 4'h3, 4'h2, 4'h1
  };

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic         s_axis_tlast  = 1'b0;   // last_byte
  logic         s_axis_tuser  = 1'b0;   // [0] empty_block
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [1:0] status, [33:2] time_cost, [65:34] memory_kib, [97:66] lanes,
  // [129:98] kdf_revision, [145:130] mode_code, [146] want_password,
  // [147] want_biometric, [148] want_keyfile, [149] want_token,
  // [150] mode_seen, [151] zero
  logic [151:0] m_axis_tdata;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_index_i   = 1'b0;
  logic [31:0]  cfg_wdata_i   = 32'h0;

  kdf_tlv_block_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Words waiting for the driver, and result words that accepted block ends owe.
  kdfp_pkg::kdfp_item_t   words_to_send[$];
  kdfp_pkg::kdfp_result_t due_results[$];
  logic [7:0]   blk_bytes[$];
  int           words_queued   = 0;
  int           words_accepted = 0;
  int           mismatch_count = 0;

  // Traffic shaping: calm turns off random idling, hold_asked starts a stall.
  logic         calm       = 1'b0;
  int           hold_asked = 0;
  int           hold_seen  = 0;
  int           hold_left  = 0;

  // Configuration as the parser should see it.
  logic [3:0]   flags_cfg;
  logic [31:0]  key_size_cfg;

  // Parser model state.
  kdfp_pkg::kdfp_phase_e blk_phase;
  int           blk_pos;
  logic [31:0]  tlvs_left;
  logic [31:0]  value_left;
  logic [15:0]  tlv_type;
  logic [31:0]  hdr_acc;
  logic [31:0]  val_acc;
  logic [1:0]   first_err;
  logic [31:0]  cost_val;
  logic [31:0]  memory_val;
  logic [31:0]  lanes_val;
  logic [31:0]  revision_val;
  logic [15:0]  mode_code_q;
  logic [3:0]   mode_factor;
  logic         mode_seen_q;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // Back to the start of a block; the configuration is kept.
  function automatic void restart_block();
    blk_phase    = kdfp_pkg::PH_PREAMBLE;
    blk_pos      = 0;
    tlvs_left    = '0;
    value_left   = '0;
    tlv_type     = '0;
    hdr_acc      = '0;
    val_acc      = '0;
    first_err    = kdfp_pkg::ST_OK;
    cost_val     = kdfp_pkg::DEF_TIME_COST;
    memory_val   = kdfp_pkg::DEF_MEMORY;
    lanes_val    = kdfp_pkg::DEF_LANES;
    revision_val = kdfp_pkg::DEF_REVISION;
    mode_code_q  = '0;
    mode_factor  = kdfp_pkg::DEF_MODE_BITS;
    mode_seen_q  = 1'b0;
  endfunction

  // The first error freezes the block: later bytes are ignored.
  function automatic void abort_block(input logic [1:0] code);
    first_err = code;
    blk_phase = kdfp_pkg::PH_DONE;
  endfunction

  function automatic void end_tlv();
    tlvs_left = tlvs_left - 1;
    blk_phase = (tlvs_left == 0) ? kdfp_pkg::PH_DONE : kdfp_pkg::PH_HEADER;
    blk_pos   = 0;
  endfunction

  function automatic void close_value();
    case (tlv_type)
      kdfp_pkg::TYPE_TIME_COST: cost_val = val_acc;
      kdfp_pkg::TYPE_MEMORY:    memory_val = val_acc;
      kdfp_pkg::TYPE_LANES:     lanes_val = val_acc;
      kdfp_pkg::TYPE_REVISION:  revision_val = val_acc;
      kdfp_pkg::TYPE_KEY_SIZE: begin
        if (val_acc != key_size_cfg) begin
          abort_block(kdfp_pkg::ST_FORMAT);
          return;
        end
      end
      kdfp_pkg::TYPE_MODE: begin
        // Two value bytes were shifted in from the top, so the code sits high.
        mode_code_q = val_acc[31:16];
        mode_seen_q = 1'b1;
        if (mode_code_q < kdfp_pkg::MODE_CODE_LIMIT) begin
          mode_factor = FACTOR_SETS[{mode_code_q[3:0], 2'b00} +: 4];
        end else begin
          mode_factor = 4'h0;
          abort_block(kdfp_pkg::ST_FORMAT);
          return;
        end
      end
      default: ;
    endcase
    end_tlv();
  endfunction

  // Known types must carry their own length; unknown ones take any length.
  function automatic void close_header();
    logic [31:0] need;
    case (tlv_type)
      kdfp_pkg::TYPE_TIME_COST, kdfp_pkg::TYPE_MEMORY, kdfp_pkg::TYPE_LANES,
      kdfp_pkg::TYPE_KEY_SIZE, kdfp_pkg::TYPE_REVISION: need = kdfp_pkg::LEN_WORD;
      kdfp_pkg::TYPE_MODE: need = kdfp_pkg::LEN_MODE;
      default:             need = hdr_acc;
    endcase
    if (hdr_acc != need) begin
      abort_block(kdfp_pkg::ST_FORMAT);
      return;
    end
    value_left = hdr_acc;
    val_acc    = '0;
    if (hdr_acc == 0) begin
      end_tlv();
    end else begin
      blk_phase = kdfp_pkg::PH_VALUE;
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    int i;
    i = blk_pos;
    case (blk_phase)
      kdfp_pkg::PH_PREAMBLE: begin
        if (i < 4) hdr_acc[8*i +: 8] = b;
        else val_acc[8*(i-4) +: 8] = b;
        blk_pos = (i + 1) % 8;
        if (i == 7) begin
          if (hdr_acc != kdfp_pkg::VERSION_1_0) begin
            abort_block(kdfp_pkg::ST_VERSION);
          end else begin
            tlvs_left = val_acc;
            blk_phase = (tlvs_left == 0) ? kdfp_pkg::PH_DONE : kdfp_pkg::PH_HEADER;
          end
        end
      end
      kdfp_pkg::PH_HEADER: begin
        if (i == 0) begin
          tlv_type = {8'h00, b};
          hdr_acc  = '0;
        end else if (i == 1) begin
          tlv_type[15:8] = b;
        end else if (i >= 4) begin
          hdr_acc[8*(i-4) +: 8] = b;
        end
        blk_pos = (i + 1) % 8;
        if (i == 7) close_header();
      end
      kdfp_pkg::PH_VALUE: begin
        val_acc    = {b, val_acc[31:8]};
        value_left = value_left - 1;
        if (value_left == 0) close_value();
      end
      default: ;
    endcase
  endfunction

  // One accepted word; a block end queues the result word it must produce.
  function automatic void parse_word(input kdfp_pkg::kdfp_item_t w);
    kdfp_pkg::kdfp_result_t r;
    logic [3:0]   bits;
    if (!w.empty_block) take_byte(w.data_byte);
    if (!w.empty_block && !w.last_byte) return;
    if (first_err != kdfp_pkg::ST_OK) r.status = first_err;
    else if (blk_phase != kdfp_pkg::PH_DONE) r.status = kdfp_pkg::ST_FORMAT;
    else if (mode_seen_q && mode_factor != flags_cfg) r.status = kdfp_pkg::ST_FORMAT;
    else r.status = kdfp_pkg::ST_OK;
    bits             = mode_seen_q ? mode_factor : flags_cfg;
    r.time_cost      = cost_val;
    r.memory_kib     = memory_val;
    r.lanes          = lanes_val;
    r.kdf_revision   = revision_val;
    r.mode_code      = mode_code_q;
    r.want_password  = bits[0];
    r.want_biometric = bits[1];
    r.want_keyfile   = bits[2];
    r.want_token     = bits[3];
    r.mode_seen      = mode_seen_q;
    due_results.push_back(r);
    restart_block();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // A word is held until taken; a new one goes out only after the handshake.
  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    kdfp_pkg::kdfp_item_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_word({s_axis_tdata, s_axis_tlast, s_axis_tuser});
        words_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (words_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          w = words_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.data_byte;
          s_axis_tlast  <= w.last_byte;
          s_axis_tuser  <= w.empty_block;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result side, counted here and started on request.
  always @(posedge clk_i or negedge rst_ni) begin : result_hold
    if (!rst_ni) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    kdfp_pkg::kdfp_result_t got;
    kdfp_pkg::kdfp_result_t want;
    logic         bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[150:0];
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result word with no block end pending: %h", $realtime, m_axis_tdata);
        end
      end else begin
        want = due_results.pop_front();
        bad = (got.status !== want.status) || (got.time_cost !== want.time_cost)
           || (got.memory_kib !== want.memory_kib) || (got.lanes !== want.lanes)
           || (got.kdf_revision !== want.kdf_revision) || (got.mode_code !== want.mode_code)
           || (got.want_password !== want.want_password)
           || (got.want_biometric !== want.want_biometric)
           || (got.want_keyfile !== want.want_keyfile)
           || (got.want_token !== want.want_token) || (got.mode_seen !== want.mode_seen)
           || (m_axis_tdata[151] !== 1'b0);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            // Factor bits print as token, key file, biometric, password.
            $display("%0t: result mismatch", $realtime);
            $display("  want st %0d tc %h mem %h ln %h rev %h mc %h f %b%b%b%b seen %b",
                     want.status, want.time_cost, want.memory_kib, want.lanes,
                     want.kdf_revision, want.mode_code, want.want_token, want.want_keyfile,
                     want.want_biometric, want.want_password, want.mode_seen);
            $display("  got  st %0d tc %h mem %h ln %h rev %h mc %h f %b%b%b%b seen %b pad %b",
                     got.status, got.time_cost, got.memory_kib, got.lanes,
                     got.kdf_revision, got.mode_code, got.want_token, got.want_keyfile,
                     got.want_biometric, got.want_password, got.mode_seen,
                     m_axis_tdata[151]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Block construction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) blk_bytes.push_back(v[8*k +: 8]);
  endtask

  // Turns blk_bytes into words. A block is closed by tlast on its final byte,
  // or by an extra empty word; a block with no bytes always takes the latter.
  task automatic queue_block(input bit end_empty);
    kdfp_pkg::kdfp_item_t w;
    int         n;
    n = blk_bytes.size();
    for (int k = 0; k < n; k++) begin
      w.data_byte   = blk_bytes[k];
      w.empty_block = 1'b0;
      w.last_byte   = (k == n - 1) && !end_empty;
      words_to_send.push_back(w);
      words_queued++;
    end
    if (end_empty || n == 0) begin
      // The byte and tlast of an empty word carry no meaning, so they are noise.
      w.data_byte   = 8'($urandom_range(0, 255));
      w.last_byte   = 1'($urandom_range(0, 1));
      w.empty_block = 1'b1;
      words_to_send.push_back(w);
      words_queued++;
    end
  endtask

  // One TLV, mostly a known type with its proper length and a sensible value.
  task automatic add_random_tlv();
    logic [15:0] kind;
    logic [31:0] len;
    logic [31:0] val;
    bit          word_type;
    int          nval;
    case ($urandom_range(0, 9))
      0:       kind = kdfp_pkg::TYPE_TIME_COST;
      1:       kind = kdfp_pkg::TYPE_MEMORY;
      2:       kind = kdfp_pkg::TYPE_LANES;
      3:       kind = kdfp_pkg::TYPE_KEY_SIZE;
      4:       kind = kdfp_pkg::TYPE_REVISION;
      5, 6:    kind = kdfp_pkg::TYPE_MODE;
      default: kind = 16'($urandom_range(0, 65535));
    endcase
    word_type = (kind == kdfp_pkg::TYPE_TIME_COST) || (kind == kdfp_pkg::TYPE_MEMORY)
             || (kind == kdfp_pkg::TYPE_LANES) || (kind == kdfp_pkg::TYPE_KEY_SIZE)
             || (kind == kdfp_pkg::TYPE_REVISION);
    if (kind == kdfp_pkg::TYPE_MODE) len = kdfp_pkg::LEN_MODE;
    else if (word_type) len = kdfp_pkg::LEN_WORD;
    else len = $urandom_range(0, 6);
    // Now and then a length that does not fit, occasionally a huge one.
    if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8);
    if (kind == kdfp_pkg::TYPE_KEY_SIZE) begin
      val = ($urandom_range(0, 6) != 0) ? key_size_cfg : rand_word();
    end else if (kind == kdfp_pkg::TYPE_MODE) begin
      val = $urandom_range(0, 14);
      // Half the time pick the code whose factor set matches the flag bits.
      if ($urandom_range(0, 1) == 1) begin
        for (int c = 0; c < 15; c++) begin
          if (FACTOR_SETS[4*c +: 4] == flags_cfg) val = c;
        end
      end
      if ($urandom_range(0, 7) == 0) val = $urandom_range(15, 65535);
    end else begin
      val = rand_word();
    end
    put_le(32'(kind), 2);
    put_le($urandom, 2);
    put_le(len, 4);
    nval = (len > 8) ? $urandom_range(0, 8) : len;
    for (int k = 0; k < nval; k++) begin
      blk_bytes.push_back((k < 4) ? val[8*k +: 8] : 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed blocks with random content; the rest are empty blocks,
  // noise, and blocks with a bad version, a wrong count, extra bytes or a cut.
  task automatic queue_random_block();
    int          sel;
    int          n_tlv;
    int          cut;
    logic [31:0] count;
    logic [31:0] ver;
    bit          end_empty;
    blk_bytes.delete();
    sel       = $urandom_range(0, 99);
    end_empty = ($urandom_range(0, 6) == 0);
    if (sel < 5) begin
      end_empty = 1'b1;
    end else if (sel < 15) begin
      repeat ($urandom_range(1, 20)) blk_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_tlv = $urandom_range(0, 5);
      count = n_tlv;
      case ($urandom_range(0, 11))
        0:       count = n_tlv + 1;
        1:       if (n_tlv > 0) count = n_tlv - 1;
        2:       count = $urandom;
        default: ;
      endcase
      ver = kdfp_pkg::VERSION_1_0;
      if ($urandom_range(0, 11) == 0) begin
        ver = $urandom_range(0, 1) ? $urandom
            : (kdfp_pkg::VERSION_1_0 ^ (32'h1 << $urandom_range(0, 31)));
      end
      put_le(ver, 4);
      put_le(count, 4);
      repeat (n_tlv) add_random_tlv();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) blk_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, blk_bytes.size());
        while (blk_bytes.size() > cut) void'(blk_bytes.pop_back());
      end
    end
    queue_block(end_empty);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == kdfp_pkg::CFG_FLAG_BITS) flags_cfg = val[3:0];
    else key_size_cfg = val;
  endtask

  // Idle means every queued word taken and every owed result word seen; the
  // extra cycles cover a word that was still being parsed at that point.
  task automatic wait_drained();
    while (words_accepted != words_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [3:0]  set_flags;
    logic [31:0] set_key;
    int          target;
    flags_cfg    = kdfp_pkg::RST_FLAG_BITS;
    key_size_cfg = kdfp_pkg::RST_KEY_SIZE;
    restart_block();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0: begin
          set_flags = kdfp_pkg::RST_FLAG_BITS;
          set_key   = kdfp_pkg::RST_KEY_SIZE;
        end
        1:       begin set_flags = 4'h0;          set_key = 32'h0000_0000; end
        2:       begin set_flags = 4'hF;          set_key = 32'hFFFF_FFFF; end
        5:       begin set_flags = 4'h8;          set_key = 32'd64; end
        default: begin set_flags = 4'($urandom_range(0, 15)); set_key = rand_word(); end
      endcase
      // Upper write data bits above the flag register are junk on purpose.
      write_reg(kdfp_pkg::CFG_FLAG_BITS, {28'($urandom), set_flags});
      write_reg(kdfp_pkg::CFG_KEY_SIZE, set_key);
      calm <= (ph == 3);

      if (ph == 0) begin
        // Zero-length block.
        blk_bytes.delete();
        queue_block(1'b1);
        // Short preamble closed by an empty word after three bytes.
        blk_bytes = '{8'h01, 8'h00, 8'h00};
        queue_block(1'b1);
        // All-ones preamble: unsupported version, the count is never used.
        blk_bytes.delete();
        put_le(32'hFFFF_FFFF, 4);
        put_le(32'hFFFF_FFFF, 4);
        queue_block(1'b0);
        // One composite-mode TLV with the largest code, which is invalid.
        blk_bytes.delete();
        put_le(kdfp_pkg::VERSION_1_0, 4);
        put_le(32'd1, 4);
        put_le(32'(kdfp_pkg::TYPE_MODE), 2);
        put_le(32'h0, 2);
        put_le(kdfp_pkg::LEN_MODE, 4);
        put_le(32'hFFFF, 2);
        queue_block(1'b0);
      end

      if (ph == 2) begin
        // Stall the result side while a run of short blocks keeps coming, so
        // that both parser registers fill and the input side backs up.
        hold_asked <= hold_asked + 1;
        for (int k = 0; k < 40; k++) begin
          blk_bytes.delete();
          repeat ($urandom_range(0, 3)) blk_bytes.push_back(8'($urandom_range(0, 255)));
          queue_block(1'($urandom_range(0, 1)));
        end
      end

      target = words_queued + PHASE_WORDS;
      while (words_queued < target) queue_random_block();
      wait_drained();
    end

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- kdf_tlv_block_parser.f -----
hdl/kdfp_pkg.sv
hdl/kdfp_in_reg.sv
hdl/kdfp_core.sv
hdl/kdfp_out_reg.sv
hdl/kdf_tlv_block_parser.sv
hdl/kdfp_checker.sv
verif/kdf_tlv_block_parser_tb.sv
